@@ sv/fdsa_pkg.sv @@
// package for the forth data-stack alu: primitive codes, status codes,
// sequencer states and the request, response and phase types of the multiply/divide unit
// no dependencies
`timescale 1ns / 1ps

package fdsa_pkg;

    localparam int CELL_WIDTH_DEF  = 32;
    localparam int STACK_DEPTH_DEF = 32;
    localparam int MODE_WIDTH      = 5;
    localparam int LIT_WIDTH       = 32;
    localparam int IN_DATA_WIDTH   = ((MODE_WIDTH + LIT_WIDTH + 7) / 8) * 8;

    localparam logic [63:0] EMPTY_MARK = 64'h0000_0000_deca_fbad;

    typedef enum logic [4:0] {
        OP_NOP     = 5'd0,
        OP_LIT     = 5'd1,
        OP_ADD     = 5'd2,
        OP_AND     = 5'd3,
        OP_OR      = 5'd4,
        OP_XOR     = 5'd5,
        OP_NEGATE  = 5'd6,
        OP_INVERT  = 5'd7,
        OP_SHL1    = 5'd8,
        OP_SHR1    = 5'd9,
        OP_USHR1   = 5'd10,
        OP_LSHIFT  = 5'd11,
        OP_RSHIFT  = 5'd12,
        OP_URSHIFT = 5'd13,
        OP_MUL     = 5'd14,
        OP_UDIVMOD = 5'd15,
        OP_FDIVMOD = 5'd16,
        OP_PICK    = 5'd17,
        OP_DUP     = 5'd18,
        OP_NIP     = 5'd19,
        OP_DROP    = 5'd20,
        OP_2DROP   = 5'd21,
        OP_DROPS   = 5'd22,
        OP_SWAP    = 5'd23,
        OP_OVER    = 5'd24,
        OP_ULESS   = 5'd25,
        OP_LESS    = 5'd26,
        OP_ZLESS   = 5'd27,
        OP_ZEQU    = 5'd28,
        OP_DEPTH   = 5'd29,
        OP_RESET   = 5'd30
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_UNDER = 2'd1,
        ST_OVER  = 2'd2,
        ST_DIVZ  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_MD,
        S_PICK,
        S_PWR,
        S_WR2,
        S_FETCH,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        MD_MUL,
        MD_UDIV,
        MD_SDIV
    } md_op_t;

    typedef enum logic [1:0] {
        MP_IDLE,
        MP_RUN,
        MP_FIX,
        MP_DONE
    } md_phase_t;

    typedef struct packed {
        logic   start;
        md_op_t op;
    } md_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } md_rsp_t;

endpackage

@@ sv/forth_data_stack_alu_top.sv @@
// forth data-stack alu top: sequencer, primitive datapath, output register
// depends on fdsa_pkg, fdsa_stack_mem, fdsa_muldiv
// sequence: S_READ applies most primitives and writes back, S_FETCH reads the new
//   top two cells and S_DONE loads the result register; pick adds S_PICK and S_PWR,
//   swap and divmod add S_WR2, multiply and divmod wait in S_MD for the unit
// one request at a time: s_tready is high only in S_IDLE, and S_DONE holds while
//   the result register is stalled
// reset: aresetn synchronous active low empties the stack, no clearing pass
`timescale 1ns / 1ps

module forth_data_stack_alu_top
    import fdsa_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int CELL_WIDTH  = CELL_WIDTH_DEF,
    localparam int AW         = $clog2(STACK_DEPTH),
    localparam int DW         = $clog2(STACK_DEPTH + 1),
    localparam int OUT_W      = ((2 * CELL_WIDTH + DW + 2 + 7) / 8) * 8
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [IN_DATA_WIDTH-1:0] s_tdata,  // mode, literal_value
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [OUT_W-1:0]         m_tdata   // top_cell, second_cell, stack_depth, status
);

    localparam int C   = CELL_WIDTH;
    localparam int SHW = $clog2(CELL_WIDTH);

    state_t          state_reg, state_next, exec_next;
    op_t             mode_reg;
    logic [LIT_WIDTH-1:0] lit_reg;
    logic [DW-1:0]   depth_reg, depth_next;
    status_t         status_reg, status_next;
    logic [C-1:0]    t_reg, n_reg;

    logic            m_valid_reg;
    logic [C-1:0]    top_reg, second_reg;
    logic [DW-1:0]   out_depth_reg;
    status_t         out_status_reg;

    logic            mem_we;
    logic [AW-1:0]   waddr, raddr0, raddr1, am1, am2, apick;
    logic [C-1:0]    wdata, rd0, rd1;
    logic [DW-1:0]   dm1, dm2, dpick;

    md_req_t         md_req;
    md_rsp_t         md_rsp;
    logic [C-1:0]    md_q, md_r;

    logic            have1, have2, slot_free, sh_big;
    logic [C-1:0]    t, n, d_c, lit_c, bin_res, un_res;
    logic [SHW-1:0]  sh;

    fdsa_stack_mem #(.DEPTH(STACK_DEPTH), .WIDTH(C)) u_mem (
        .aclk   (aclk),
        .we     (mem_we),
        .waddr  (waddr),
        .wdata  (wdata),
        .raddr0 (raddr0),
        .raddr1 (raddr1),
        .rdata0 (rd0),
        .rdata1 (rd1)
    );

    fdsa_muldiv #(.W(C)) u_md (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (md_req),
        .a       (n),
        .b       (t),
        .rsp     (md_rsp),
        .q       (md_q),
        .r       (md_r)
    );

    assign s_tready  = (state_reg == S_IDLE);
    assign slot_free = !m_valid_reg || m_tready;

    assign dm1    = depth_reg - DW'(1);
    assign dm2    = depth_reg - DW'(2);
    assign dpick  = dm2 - t_reg[DW-1:0];
    assign am1    = dm1[AW-1:0];
    assign am2    = dm2[AW-1:0];
    assign apick  = dpick[AW-1:0];
    assign raddr0 = (state_reg == S_PICK) ? apick : am1;
    assign raddr1 = am2;

    assign have1  = (depth_reg != '0);
    assign have2  = (depth_reg >= DW'(2));
    assign t      = have1 ? rd0 : '0;
    assign n      = have2 ? rd1 : '0;
    assign d_c    = C'(depth_reg);
    assign lit_c  = C'($signed(lit_reg));
    assign sh_big = (t >= C'(CELL_WIDTH));
    assign sh     = t[SHW-1:0];

    always_comb begin
        unique case (mode_reg)
            OP_ADD:     bin_res = n + t;
            OP_AND:     bin_res = n & t;
            OP_OR:      bin_res = n | t;
            OP_XOR:     bin_res = n ^ t;
            OP_LSHIFT:  bin_res = sh_big ? '0 : (n << sh);
            OP_RSHIFT:  bin_res = sh_big ? {C{n[C-1]}} : C'($signed(n) >>> sh);
            OP_URSHIFT: bin_res = sh_big ? '0 : (n >> sh);
            OP_ULESS:   bin_res = (n < t) ? '1 : '0;
            OP_LESS:    bin_res = ($signed(n) < $signed(t)) ? '1 : '0;
            default:    bin_res = t;
        endcase
        unique case (mode_reg)
            OP_NEGATE: un_res = C'(0) - t;
            OP_INVERT: un_res = ~t;
            OP_SHL1:   un_res = t << 1;
            OP_SHR1:   un_res = {t[C-1], t[C-1:1]};
            OP_USHR1:  un_res = {1'b0, t[C-1:1]};
            OP_ZLESS:  un_res = t[C-1] ? '1 : '0;
            default:   un_res = (t == '0) ? '1 : '0;
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (s_tvalid) state_next = S_READ;
            S_READ:  state_next = exec_next;
            S_MD: begin
                if (md_rsp.done) begin
                    state_next = (mode_reg == OP_MUL) ? S_FETCH : S_WR2;
                end
            end
            S_PICK:  state_next = S_PWR;
            S_PWR:   state_next = S_FETCH;
            S_WR2:   state_next = S_FETCH;
            S_FETCH: state_next = S_DONE;
            S_DONE:  if (slot_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // datapath control and write-back
    always_comb begin
        exec_next   = S_FETCH;
        depth_next  = depth_reg;
        status_next = status_reg;
        mem_we      = 1'b0;
        waddr       = am1;
        wdata       = t;
        md_req      = '{start: 1'b0, op: MD_MUL};
        unique case (state_reg)
            S_READ: begin
                status_next = ST_OK;
                unique case (mode_reg)
                    OP_LIT, OP_DUP, OP_DEPTH, OP_OVER: begin
                        if ((mode_reg == OP_DUP && !have1) ||
                            (mode_reg == OP_OVER && !have2)) begin
                            status_next = ST_UNDER;
                        end else if (depth_reg >= DW'(STACK_DEPTH)) begin
                            status_next = ST_OVER;
                        end else begin
                            mem_we     = 1'b1;
                            waddr      = depth_reg[AW-1:0];
                            depth_next = depth_reg + DW'(1);
                            if (mode_reg == OP_LIT) begin
                                wdata = lit_c;
                            end else if (mode_reg == OP_DEPTH) begin
                                wdata = d_c;
                            end else if (mode_reg == OP_OVER) begin
                                wdata = n;
                            end
                        end
                    end
                    OP_ADD, OP_AND, OP_OR, OP_XOR, OP_LSHIFT, OP_RSHIFT,
                    OP_URSHIFT, OP_ULESS, OP_LESS, OP_NIP: begin
                        if (!have2) begin
                            status_next = ST_UNDER;
                        end else begin
                            mem_we     = 1'b1;
                            waddr      = am2;
                            wdata      = bin_res;
                            depth_next = dm1;
                        end
                    end
                    OP_NEGATE, OP_INVERT, OP_SHL1, OP_SHR1, OP_USHR1,
                    OP_ZLESS, OP_ZEQU: begin
                        if (!have1) begin
                            status_next = ST_UNDER;
                        end else begin
                            mem_we = 1'b1;
                            wdata  = un_res;
                        end
                    end
                    OP_MUL, OP_UDIVMOD, OP_FDIVMOD: begin
                        if (!have2) begin
                            status_next = ST_UNDER;
                        end else if (mode_reg != OP_MUL && t == '0) begin
                            status_next = ST_DIVZ;
                        end else begin
                            md_req.start = 1'b1;
                            md_req.op    = (mode_reg == OP_MUL) ? MD_MUL :
                                           (mode_reg == OP_UDIVMOD) ? MD_UDIV : MD_SDIV;
                            exec_next    = S_MD;
                        end
                    end
                    OP_PICK: begin
                        if (!have1 || t >= d_c - C'(1)) begin
                            status_next = ST_UNDER;
                        end else begin
                            exec_next = S_PICK;
                        end
                    end
                    OP_DROP: begin
                        if (!have1) status_next = ST_UNDER;
                        else depth_next = dm1;
                    end
                    OP_2DROP: begin
                        if (!have2) status_next = ST_UNDER;
                        else depth_next = dm2;
                    end
                    OP_DROPS: begin
                        if (!have1 || t > d_c - C'(1)) begin
                            status_next = ST_UNDER;
                        end else begin
                            depth_next = dm1 - t[DW-1:0];
                        end
                    end
                    OP_SWAP: begin
                        if (!have2) begin
                            status_next = ST_UNDER;
                        end else begin
                            mem_we    = 1'b1;
                            wdata     = n;
                            exec_next = S_WR2;
                        end
                    end
                    OP_RESET: depth_next = '0;
                    default: begin
                    end
                endcase
            end
            S_MD: begin
                if (md_rsp.done) begin
                    mem_we = 1'b1;
                    waddr  = am2;
                    wdata  = md_r;
                    if (mode_reg == OP_MUL) begin
                        wdata      = md_q;
                        depth_next = dm1;
                    end
                end
            end
            S_PWR: begin
                mem_we = 1'b1;
                wdata  = rd0;
            end
            S_WR2: begin
                mem_we = 1'b1;
                if (mode_reg == OP_SWAP) begin
                    waddr = am2;
                    wdata = t_reg;
                end else begin
                    wdata = md_q;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            depth_reg   <= '0;
            status_reg  <= ST_OK;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            depth_reg  <= depth_next;
            status_reg <= status_next;
            if (state_reg == S_DONE && slot_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (state_reg == S_IDLE) begin
            mode_reg <= op_t'(s_tdata[MODE_WIDTH-1:0]);
            lit_reg  <= s_tdata[MODE_WIDTH +: LIT_WIDTH];
        end
        if (state_reg == S_READ) begin
            t_reg <= t;
            n_reg <= n;
        end
        if (state_reg == S_DONE && slot_free) begin
            top_reg        <= have1 ? rd0 : EMPTY_MARK[C-1:0];
            second_reg     <= have2 ? rd1 : '0;
            out_depth_reg  <= depth_reg;
            out_status_reg <= status_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_W'({out_status_reg, out_depth_reg, second_reg, top_reg});

`ifndef SYNTH
    a_write_state : assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (state_reg == S_READ || state_reg == S_MD ||
                    state_reg == S_PWR || state_reg == S_WR2))
        else $error("stack write outside a write-back cycle");

    a_depth_bound : assert property (@(posedge aclk) disable iff (!aresetn)
        depth_reg <= DW'(STACK_DEPTH))
        else $error("stack depth beyond capacity");

    a_over_full : assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_READ && status_next == ST_OVER) |-> depth_reg == DW'(STACK_DEPTH))
        else $error("overflow reported on a stack with room");

    a_md_done : assert property (@(posedge aclk) disable iff (!aresetn)
        md_rsp.done |-> state_reg == S_MD)
        else $error("mul/div result with no primitive waiting");

    a_n_cached : assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_READ && !have2) |=> n_reg == '0)
        else $error("second cell cached from below the stack");
`endif

endmodule

@@ sv/fdsa_stack_mem.sv @@
// stack cell memory: one write port, two registered read ports
// uses fdsa_pkg for the default depth and width parameters
`timescale 1ns / 1ps

module fdsa_stack_mem
    import fdsa_pkg::*;
#(
    parameter int DEPTH = STACK_DEPTH_DEF,
    parameter int WIDTH = CELL_WIDTH_DEF,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr0,
    input  logic [AW-1:0]    raddr1,
    output logic [WIDTH-1:0] rdata0,
    output logic [WIDTH-1:0] rdata1
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata0 <= mem[raddr0];
        rdata1 <= mem[raddr1];
    end

endmodule

@@ sv/fdsa_muldiv.sv @@
// iterative multiply and divide unit, one bit per cycle
// unsigned and floored signed divmod; depends on fdsa_pkg
`timescale 1ns / 1ps

module fdsa_muldiv
    import fdsa_pkg::*;
#(
    parameter int W = CELL_WIDTH_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  md_req_t      req,
    input  logic [W-1:0] a,
    input  logic [W-1:0] b,
    output md_rsp_t      rsp,
    output logic [W-1:0] q,
    output logic [W-1:0] r
);

    localparam int CW = $clog2(W + 1);

    md_phase_t      phase_reg, phase_next;
    md_op_t         op_reg;
    logic [CW-1:0]  cnt_reg;
    logic [W-1:0]   acc_reg, quo_reg, opd_reg, b_reg, q_reg, r_reg;
    logic           na_reg, nb_reg;

    logic [W:0]     rem_w, diff;
    logic [W-1:0]   qq, rr;
    logic           sgn_diff;

    always_comb begin
        phase_next = phase_reg;
        unique case (phase_reg)
            MP_IDLE: if (req.start) phase_next = MP_RUN;
            MP_RUN:  if (cnt_reg == CW'(1)) phase_next = MP_FIX;
            MP_FIX:  phase_next = MP_DONE;
            MP_DONE: phase_next = MP_IDLE;
            default: phase_next = MP_IDLE;
        endcase
    end

    always_comb begin
        rem_w    = {acc_reg, quo_reg[W-1]};
        diff     = rem_w - {1'b0, opd_reg};
        sgn_diff = na_reg ^ nb_reg;
        qq       = sgn_diff ? (W'(0) - quo_reg) : quo_reg;
        rr       = na_reg ? (W'(0) - acc_reg) : acc_reg;
        // floored: nonzero remainder takes the divisor's sign
        if (rr != '0 && sgn_diff) begin
            qq = qq - W'(1);
            rr = rr + b_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= MP_IDLE;
        end else begin
            phase_reg <= phase_next;
        end
        unique case (phase_reg)
            MP_IDLE: begin
                op_reg  <= req.op;
                cnt_reg <= CW'(W);
                acc_reg <= '0;
                b_reg   <= b;
                na_reg  <= (req.op == MD_SDIV) && a[W-1];
                nb_reg  <= (req.op == MD_SDIV) && b[W-1];
                if (req.op == MD_MUL) begin
                    opd_reg <= a;
                    quo_reg <= b;
                end else if (req.op == MD_SDIV) begin
                    quo_reg <= a[W-1] ? (W'(0) - a) : a;
                    opd_reg <= b[W-1] ? (W'(0) - b) : b;
                end else begin
                    quo_reg <= a;
                    opd_reg <= b;
                end
            end
            MP_RUN: begin
                cnt_reg <= cnt_reg - CW'(1);
                if (op_reg == MD_MUL) begin
                    if (quo_reg[0]) begin
                        acc_reg <= acc_reg + opd_reg;
                    end
                    opd_reg <= opd_reg << 1;
                    quo_reg <= quo_reg >> 1;
                end else if (!diff[W]) begin
                    acc_reg <= diff[W-1:0];
                    quo_reg <= {quo_reg[W-2:0], 1'b1};
                end else begin
                    acc_reg <= rem_w[W-1:0];
                    quo_reg <= {quo_reg[W-2:0], 1'b0};
                end
            end
            MP_FIX: begin
                if (op_reg == MD_MUL) begin
                    q_reg <= acc_reg;
                    r_reg <= acc_reg;
                end else begin
                    q_reg <= qq;
                    r_reg <= rr;
                end
            end
            default: begin
            end
        endcase
    end

    assign rsp.busy = (phase_reg != MP_IDLE);
    assign rsp.done = (phase_reg == MP_DONE);
    assign q        = q_reg;
    assign r        = r_reg;

endmodule

@@ sim/tb_forth_data_stack_alu_top.sv @@
// testbench for forth_data_stack_alu_top: random and directed primitive requests
// checked against a scoreboard that models the stack; depends on fdsa_pkg and the rtl
`timescale 1ns / 1ps

class stack_scoreboard;
    localparam int DEPTH_MAX = 32;
    localparam logic [31:0] EMPTY_CELL = 32'hdecafbad;
    localparam logic [31:0] FLAG_TRUE = 32'hffff_ffff;

    logic [31:0] cells [DEPTH_MAX];
    int depth;
    logic [71:0] pending_results [$];
    int errors;

    function new();
        depth = 0;
        errors = 0;
    endfunction

    // apply one primitive to the model stack and queue the expected result
    function void note_request(logic [4:0] mode, logic [31:0] lit);
        logic [31:0] t, n, r, q;
        fdsa_pkg::status_t st;
        longint sa, sb, sq, sr;
        t = (depth >= 1) ? cells[depth-1] : 32'd0;
        n = (depth >= 2) ? cells[depth-2] : 32'd0;
        st = fdsa_pkg::ST_OK;
        case (mode)
            fdsa_pkg::OP_LIT, fdsa_pkg::OP_DUP, fdsa_pkg::OP_DEPTH, fdsa_pkg::OP_OVER: begin
                if ((mode == fdsa_pkg::OP_DUP && depth < 1) ||
                    (mode == fdsa_pkg::OP_OVER && depth < 2)) st = fdsa_pkg::ST_UNDER;
                else if (depth >= DEPTH_MAX) st = fdsa_pkg::ST_OVER;
                else begin
                    case (mode)
                        fdsa_pkg::OP_LIT:  cells[depth] = lit;
                        fdsa_pkg::OP_DUP:  cells[depth] = t;
                        fdsa_pkg::OP_OVER: cells[depth] = n;
                        default:           cells[depth] = depth;
                    endcase
                    depth++;
                end
            end
            fdsa_pkg::OP_ADD, fdsa_pkg::OP_AND, fdsa_pkg::OP_OR, fdsa_pkg::OP_XOR,
            fdsa_pkg::OP_LSHIFT, fdsa_pkg::OP_RSHIFT, fdsa_pkg::OP_URSHIFT,
            fdsa_pkg::OP_MUL, fdsa_pkg::OP_ULESS, fdsa_pkg::OP_LESS, fdsa_pkg::OP_NIP: begin
                if (depth < 2) st = fdsa_pkg::ST_UNDER;
                else begin
                    case (mode)
                        fdsa_pkg::OP_ADD:     r = n + t;
                        fdsa_pkg::OP_AND:     r = n & t;
                        fdsa_pkg::OP_OR:      r = n | t;
                        fdsa_pkg::OP_XOR:     r = n ^ t;
                        fdsa_pkg::OP_LSHIFT:  r = (t >= 32) ? 32'd0 : n << t[4:0];
                        fdsa_pkg::OP_RSHIFT:  r = (t >= 32) ? {32{n[31]}}
                                                            : 32'($signed(n) >>> t[4:0]);
                        fdsa_pkg::OP_URSHIFT: r = (t >= 32) ? 32'd0 : n >> t[4:0];
                        fdsa_pkg::OP_MUL:     r = n * t;
                        fdsa_pkg::OP_ULESS:   r = (n < t) ? FLAG_TRUE : 32'd0;
                        fdsa_pkg::OP_LESS:    r = ($signed(n) < $signed(t)) ? FLAG_TRUE : 32'd0;
                        default:              r = t;
                    endcase
                    cells[depth-2] = r;
                    depth--;
                end
            end
            fdsa_pkg::OP_NEGATE, fdsa_pkg::OP_INVERT, fdsa_pkg::OP_SHL1, fdsa_pkg::OP_SHR1,
            fdsa_pkg::OP_USHR1, fdsa_pkg::OP_ZLESS, fdsa_pkg::OP_ZEQU: begin
                if (depth < 1) st = fdsa_pkg::ST_UNDER;
                else begin
                    case (mode)
                        fdsa_pkg::OP_NEGATE: r = -t;
                        fdsa_pkg::OP_INVERT: r = ~t;
                        fdsa_pkg::OP_SHL1:   r = t << 1;
                        fdsa_pkg::OP_SHR1:   r = $signed(t) >>> 1;
                        fdsa_pkg::OP_USHR1:  r = t >> 1;
                        fdsa_pkg::OP_ZLESS:  r = t[31] ? FLAG_TRUE : 32'd0;
                        default:             r = (t == 0) ? FLAG_TRUE : 32'd0;
                    endcase
                    cells[depth-1] = r;
                end
            end
            fdsa_pkg::OP_UDIVMOD, fdsa_pkg::OP_FDIVMOD: begin
                if (depth < 2) st = fdsa_pkg::ST_UNDER;
                else if (t == 0) st = fdsa_pkg::ST_DIVZ;
                else begin
                    if (mode == fdsa_pkg::OP_UDIVMOD) begin
                        q = n / t;
                        r = n % t;
                    end else begin
                        // 64-bit math keeps most-negative over -1 from trapping
                        sa = longint'($signed(n));
                        sb = longint'($signed(t));
                        sq = sa / sb;
                        sr = sa % sb;
                        if (sr != 0 && ((sr < 0) != (sb < 0))) begin
                            sq = sq - 1;
                            sr = sr + sb;
                        end
                        q = sq[31:0];
                        r = sr[31:0];
                    end
                    cells[depth-2] = r;
                    cells[depth-1] = q;
                end
            end
            fdsa_pkg::OP_PICK: begin
                if (depth < 1 || t >= depth - 1) st = fdsa_pkg::ST_UNDER;
                else cells[depth-1] = cells[depth-2-int'(t)];
            end
            fdsa_pkg::OP_DROP, fdsa_pkg::OP_2DROP: begin
                if (depth < ((mode == fdsa_pkg::OP_DROP) ? 1 : 2)) st = fdsa_pkg::ST_UNDER;
                else depth -= (mode == fdsa_pkg::OP_DROP) ? 1 : 2;
            end
            fdsa_pkg::OP_DROPS: begin
                if (depth < 1 || t > depth - 1) st = fdsa_pkg::ST_UNDER;
                else depth -= int'(t) + 1;
            end
            fdsa_pkg::OP_SWAP: begin
                if (depth < 2) st = fdsa_pkg::ST_UNDER;
                else begin
                    cells[depth-1] = n;
                    cells[depth-2] = t;
                end
            end
            fdsa_pkg::OP_RESET: depth = 0;
            default: ;
        endcase
        pending_results.push_back({st, 6'(depth),
                                   (depth >= 2) ? cells[depth-2] : 32'd0,
                                   (depth >= 1) ? cells[depth-1] : EMPTY_CELL});
    endfunction

    function void check_result(logic [71:0] got);
        logic [71:0] want;
        if (pending_results.size() == 0) begin
            $display("%0t: unexpected result %h", $time, got);
            errors++;
            return;
        end
        want = pending_results.pop_front();
        if (got[31:0] !== want[31:0]) begin
            $display("%0t: top_cell expected %h actual %h", $time, want[31:0], got[31:0]);
            errors++;
        end
        if (got[63:32] !== want[63:32]) begin
            $display("%0t: second_cell expected %h actual %h", $time, want[63:32], got[63:32]);
            errors++;
        end
        if (got[69:64] !== want[69:64]) begin
            $display("%0t: stack_depth expected %0d actual %0d", $time, want[69:64], got[69:64]);
            errors++;
        end
        if (got[71:70] !== want[71:70]) begin
            $display("%0t: status expected %0d actual %0d", $time, want[71:70], got[71:70]);
            errors++;
        end
    endfunction
endclass

module tb_forth_data_stack_alu_top;
    import fdsa_pkg::*;

    localparam logic [4:0] MODE_UNDEF = 5'd31;
    localparam int CYCLE_LIMIT = 600000;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;

    stack_scoreboard sb;
    int sender_idle_pct;
    int receiver_stall_pct;
    int cycles = 0;

    forth_data_stack_alu_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        aclk = 1'b1;
        #2;
        aclk = 1'b0;
        #2;
    end

    always @(negedge aclk)
        m_tready <= ($urandom_range(99) >= receiver_stall_pct);

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_forth_data_stack_alu_top: FAIL");
            $finish;
        end
    end

    task automatic send_request(logic [4:0] mode, logic [31:0] lit);
        @(negedge aclk);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, lit, mode};
        do @(posedge aclk); while (!s_tready);
        sb.note_request(mode, lit);
    endtask

    function automatic logic [31:0] pick_literal();
        case ($urandom_range(9))
            0, 1, 2, 3, 4: return $urandom_range(40);
            5:             return {$urandom_range(3) == 0, 31'd0} | (32'h7fff_ffff
                                  & {32{$urandom_range(1) == 1'b1}});
            6:             return -$urandom_range(3);
            default:       return $urandom;
        endcase
    endfunction

    task automatic random_requests(int count);
        int k;
        int lit_pct;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(99) < 2) begin
                // long push run to reach the full stack
                for (k = 0; k < 34; k++) send_request(OP_LIT, pick_literal());
            end else begin
                lit_pct = (sb.depth < 4) ? 60 : 30;
                if ($urandom_range(99) < lit_pct) send_request(OP_LIT, pick_literal());
                else send_request(5'($urandom_range(31)), $urandom);
            end
        end
    endtask

    initial begin
        sb = new();
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // empty-stack underflows and an undefined code
        send_request(OP_DROP, 32'd0);
        send_request(OP_ADD, 32'd0);
        send_request(OP_DUP, 32'd0);
        send_request(MODE_UNDEF, 32'hffff_ffff);
        send_request(OP_NOP, 32'd0);
        // most negative over -1 and divide by zero
        send_request(OP_LIT, 32'h8000_0000);
        send_request(OP_LIT, 32'hffff_ffff);
        send_request(OP_FDIVMOD, 32'd0);
        send_request(OP_LIT, 32'd0);
        send_request(OP_UDIVMOD, 32'd0);
        send_request(OP_FDIVMOD, 32'd0);
        // oversized shift counts
        send_request(OP_DROP, 32'd0);
        send_request(OP_LIT, 32'd32);
        send_request(OP_RSHIFT, 32'd0);
        send_request(OP_LIT, 32'h7fff_ffff);
        send_request(OP_LIT, 32'd40);
        send_request(OP_LSHIFT, 32'd0);
        // pick and drops past the bottom
        send_request(OP_LIT, 32'hffff_ffff);
        send_request(OP_PICK, 32'd0);
        send_request(OP_DROPS, 32'd0);
        send_request(OP_DEPTH, 32'd0);
        send_request(OP_PICK, 32'd0);
        send_request(OP_RESET, 32'd0);
        // fill the stack, then one push too many, then dup and over on the full stack
        for (int i = 0; i < 33; i++) send_request(OP_LIT, $urandom);
        send_request(OP_DUP, 32'd0);
        send_request(OP_OVER, 32'd0);
        send_request(OP_RESET, 32'd0);

        random_requests(260);
        sender_idle_pct = 59;
        random_requests(260);
        sender_idle_pct = 0;
        receiver_stall_pct = 59;
        random_requests(260);
        sender_idle_pct = 26;
        receiver_stall_pct = 26;
        random_requests(260);

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        if (sb.errors == 0)
            $display("tb_forth_data_stack_alu_top: PASS");
        else
            $display("tb_forth_data_stack_alu_top: FAIL");
        $finish;
    end
endmodule
